[rtl/pds_pkg.sv]
// shared types and constants of the polyline decimate and subdivide block
package pds_pkg;

  localparam int COORD_W       = 32;
  localparam int POINT_W       = 16;
  localparam int KEEP_W        = 8;
  localparam int EXTRA_W       = 6;
  localparam int PARTS_W       = EXTRA_W + 1;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_EXTRA_DEF = 63;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEEP_EVERY   = 2'd0,
    CFG_EXTRA_POINTS = 2'd1,
    CFG_FLIP_Y       = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ADV  = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic               interp;
    logic [EXTRA_W-1:0] n;
  } seg_t;

endpackage

[rtl/pds_if.sv]
// vertex and point channel interfaces
interface pds_vertex_if import pds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic               malformed;
  logic               line_start;

  modport source (output valid, coord_x, coord_y, malformed, line_start, input ready);
  modport sink   (input valid, coord_x, coord_y, malformed, line_start, output ready);
endinterface

interface pds_point_if import pds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] point_x;
  logic [POINT_W-1:0] point_y;
  logic               is_vertex;
  logic               last_of_run;

  modport source (output valid, point_x, point_y, is_vertex, last_of_run, input ready);
  modport sink   (input valid, point_x, point_y, is_vertex, last_of_run, output ready);
endinterface

[rtl/pds_fifo.sv]
// short segment queue between front and back
module pds_fifo import pds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seg_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output seg_t pop_data_o,
  output logic empty_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  seg_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/pds_front.sv]
// front end: config registers, stride decimation, y flip, segment classification
module pds_front import pds_pkg::*; #(
  parameter int MAX_EXTRA = MAX_EXTRA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pds_vertex_if.sink           in_vtx,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 push_o,
  output seg_t                 seg_o,
  input  logic                 full_i
);

  logic [KEEP_W-1:0]  keep_q;
  logic [EXTRA_W-1:0] extra_q;
  logic               flip_q;
  logic [KEEP_W-1:0]  phase_q, phase_d, phase_base, phase_inc;
  logic               have_prev_q, have_prev_d, have_prev_base;
  logic [COORD_W-1:0] prev_x_q, prev_y_q, y_used;
  logic [EXTRA_W-1:0] n_eff;
  logic               accept, kept, keep_item;

  assign in_vtx.ready = !full_i;
  assign accept       = in_vtx.valid && !full_i;

  always_comb begin
    phase_base     = in_vtx.line_start ? '0 : phase_q;
    have_prev_base = in_vtx.line_start ? 1'b0 : have_prev_q;
    phase_inc      = phase_base + KEEP_W'(1);
    if (keep_q <= KEEP_W'(1)) begin
      kept    = 1'b1;
      phase_d = '0;
    end else begin
      kept    = (phase_base == '0);
      phase_d = (phase_inc >= keep_q) ? '0 : phase_inc;
    end
    keep_item   = kept && !in_vtx.malformed;
    have_prev_d = keep_item ? 1'b1 : have_prev_base;

    // negating the most negative value saturates
    if (!flip_q) begin
      y_used = in_vtx.coord_y;
    end else if (in_vtx.coord_y == {1'b1, {(COORD_W-1){1'b0}}}) begin
      y_used = {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      y_used = -in_vtx.coord_y;
    end

    n_eff = (extra_q > EXTRA_W'(MAX_EXTRA)) ? EXTRA_W'(MAX_EXTRA) : extra_q;
  end

  assign push_o        = accept && keep_item;
  assign seg_o.prev_x  = prev_x_q;
  assign seg_o.prev_y  = prev_y_q;
  assign seg_o.cur_x   = in_vtx.coord_x;
  assign seg_o.cur_y   = y_used;
  assign seg_o.interp  = have_prev_base && (n_eff != '0);
  assign seg_o.n       = n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q      <= '0;
      extra_q     <= '0;
      flip_q      <= 1'b1;
      phase_q     <= '0;
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_KEEP_EVERY:   keep_q  <= cfg_wdata_i[KEEP_W-1:0];
          CFG_EXTRA_POINTS: extra_q <= cfg_wdata_i[EXTRA_W-1:0];
          CFG_FLIP_Y:       flip_q  <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_q     <= phase_d;
        have_prev_q <= have_prev_d;
        if (keep_item) begin
          prev_x_q <= in_vtx.coord_x;
          prev_y_q <= y_used;
        end
      end
    end
  end

endmodule

[rtl/pds_div.sv]
// serial restoring divider, one quotient bit per cycle
module pds_div #(
  parameter int NW  = 16,
  parameter int DVW = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           busy_o,
  output logic [NW-1:0]  quo_o,
  output logic [DVW-1:0] rem_o
);

  localparam int CW = $clog2(NW + 1);

  logic           busy_q, busy_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]  quo_q;
  logic [DVW-1:0] rem_q, dvs_q;
  logic [DVW+1:0] diff;
  logic           ge;

  assign diff   = {1'b0, rem_q, quo_q[NW-1]} - {2'b00, dvs_q};
  assign ge     = !diff[DVW+1];
  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DVW-1:0] : {rem_q[DVW-2:0], quo_q[NW-1]};
    end
  end

endmodule

[rtl/pds_back.sv]
// back end: segment step division and point generation by quotient/remainder stepping
module pds_back import pds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  output logic        pop_o,
  input  seg_t        seg_i,
  input  logic        empty_i,
  pds_point_if.source out_pt
);

  localparam int NW = COORD_W - FRAC_BITS;
  localparam int QW = NW + 2;
  localparam int RW = FRAC_BITS + PARTS_W;
  localparam int WW = 40;
  localparam logic [WW-1:0] LOW_MASK = (WW'(1) << FRAC_BITS) - WW'(1);

  back_state_e state_q, state_d;
  logic [PARTS_W-1:0] parts_q, parts_in, left_q, left_d;
  logic [RW-1:0]      den_q;
  logic               ovld_q, ovld_d, emit, out_free, div_start;
  logic [1:0]         busy;

  logic signed [QW-1:0]    q_q [2];
  logic signed [QW-1:0]    dq_q [2];
  logic signed [QW-1:0]    q0 [2];
  logic signed [QW-1:0]    dq_div [2];
  logic signed [QW-1:0]    q_step [2];
  logic [RW-1:0]           r_q [2];
  logic [RW-1:0]           dr_q [2];
  logic [RW-1:0]           r0 [2];
  logic [RW-1:0]           dr_div [2];
  logic [RW-1:0]           r_step [2];
  logic signed [COORD_W:0] d_q [2];
  logic signed [COORD_W:0] d_w [2];
  logic [POINT_W-1:0]      pt [2];
  logic [POINT_W-1:0]      pt_q [2];

  assign parts_in = seg_i.interp ? ({1'b0, seg_i.n} + PARTS_W'(1)) : PARTS_W'(1);

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [COORD_W-1:0]      cur, prev, sv;
    logic signed [COORD_W:0] a, ua;
    logic [NW-1:0]           quo;
    logic [PARTS_W-1:0]      rem, rp;
    logic [RW:0]             sum;
    logic                    wrap;
    logic signed [WW-1:0]    t;

    assign cur  = (g == 0) ? seg_i.cur_x : seg_i.cur_y;
    assign prev = (g == 0) ? seg_i.prev_x : seg_i.prev_y;
    assign sv   = seg_i.interp ? prev : cur;

    // start of the run: floor of the start vertex, remainder scaled by the part count
    assign q0[g] = QW'($signed({{(WW-COORD_W){sv[COORD_W-1]}}, sv}) >>> FRAC_BITS);
    assign r0[g] = RW'(WW'(sv) & LOW_MASK) * RW'(parts_in);

    // step per point: floor division of the difference by parts * 2^frac
    assign d_w[g] = $signed({cur[COORD_W-1], cur}) - $signed({prev[COORD_W-1], prev});
    assign a      = d_w[g] >>> FRAC_BITS;
    assign ua     = d_w[g][COORD_W] ? ~a : a;

    pds_div #(.NW(NW), .DVW(PARTS_W)) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (ua[NW-1:0]),
      .divisor_i  (parts_in),
      .busy_o     (busy[g]),
      .quo_o      (quo),
      .rem_o      (rem)
    );

    assign dq_div[g] = d_q[g][COORD_W] ? ~$signed({2'b00, quo}) : $signed({2'b00, quo});
    assign rp        = d_q[g][COORD_W] ? (parts_q - PARTS_W'(1) - rem) : rem;
    assign dr_div[g] = RW'((WW'(rp) << FRAC_BITS) | (WW'(d_q[g][COORD_W-1:0]) & LOW_MASK));

    assign sum       = {1'b0, r_q[g]} + {1'b0, dr_q[g]};
    assign wrap      = (sum >= {1'b0, den_q});
    assign r_step[g] = wrap ? RW'(sum - {1'b0, den_q}) : sum[RW-1:0];
    assign q_step[g] = q_q[g] + dq_q[g] + $signed({{(QW-1){1'b0}}, wrap});

    // floor to truncation toward zero, then saturate
    always_comb begin
      t = WW'(q_q[g]);
      if (q_q[g] < 0 && r_q[g] != '0) begin
        t = t + WW'(1);
      end
      if (t > WW'(32767)) begin
        pt[g] = POINT_W'(32767);
      end else if (t < -WW'(32768)) begin
        pt[g] = POINT_W'(-32768);
      end else begin
        pt[g] = t[POINT_W-1:0];
      end
    end
  end

  assign out_free = !ovld_q || out_pt.ready;

  always_comb begin
    state_d   = state_q;
    left_d    = left_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          div_start = seg_i.interp;
          left_d    = parts_in;
          state_d   = seg_i.interp ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (busy == 2'b00) begin
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit   = 1'b1;
          left_d = left_q - PARTS_W'(1);
          if (left_q == PARTS_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (emit) begin
      ovld_d = 1'b1;
    end else if (out_pt.ready) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      left_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      parts_q <= parts_in;
      den_q   <= RW'(WW'(parts_in) << FRAC_BITS);
    end
    for (int i = 0; i < 2; i++) begin
      if (pop_o) begin
        q_q[i] <= q0[i];
        r_q[i] <= r0[i];
        d_q[i] <= d_w[i];
      end else if (state_q == ST_ADV || emit) begin
        q_q[i] <= q_step[i];
        r_q[i] <= r_step[i];
      end
      if (state_q == ST_DIV && busy == 2'b00) begin
        dq_q[i] <= dq_div[i];
        dr_q[i] <= dr_div[i];
      end
      if (emit) begin
        pt_q[i] <= pt[i];
      end
    end
    if (emit) begin
      out_pt.is_vertex   <= (left_q == PARTS_W'(1));
      out_pt.last_of_run <= (left_q == PARTS_W'(1));
    end
  end

  assign out_pt.valid   = ovld_q;
  assign out_pt.point_x = pt_q[0];
  assign out_pt.point_y = pt_q[1];

endmodule

[rtl/polyline_decimate_subdivide_top.sv]
// top level of the polyline decimate and subdivide block
//
// in_vtx carries one vertex per transfer: Q16.16 x and y, a malformed flag and a
// line start flag. out_pt carries the emitted integer points; is_vertex marks the
// kept vertex and last_of_run the final point caused by one input vertex.
// cfg_we_i writes register cfg_idx_i (0 keep_every, 1 extra_points, 2 flip_y)
// from cfg_wdata_i; other indexes are ignored.
// The front takes a vertex every cycle while the two-entry segment queue has room.
// A vertex with no interpolation is popped in ST_IDLE and emitted from ST_EMIT, and the
// back takes the next segment in the same cycle in which that point appears on out_pt.
// With n interpolated points the back loads the segment, runs the serial step
// dividers, takes the first step in ST_ADV and then emits n + 1 points.
// Each point costs one add and compare per coordinate once the step is known.
// Reset clears the stride phase, the line memory and the queue, and sets
// keep_every and extra_points to 0 and flip_y to 1. When the receiver stalls,
// the output register holds its point, the back waits, the queue fills and
// in_vtx.ready drops.
module polyline_decimate_subdivide_top import pds_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_EXTRA = MAX_EXTRA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pds_vertex_if.sink           in_vtx,
  pds_point_if.source          out_pt,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic push, pop, full, empty;
  seg_t push_seg, pop_seg;

  pds_front #(.MAX_EXTRA(MAX_EXTRA)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vtx      (in_vtx),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .seg_o       (push_seg),
    .full_i      (full)
  );

  pds_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_seg),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_seg),
    .empty_o     (empty)
  );

  pds_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pop_o   (pop),
    .seg_i   (pop_seg),
    .empty_i (empty),
    .out_pt  (out_pt)
  );

endmodule

[rtl/pds_checker.sv]
// port-level checks of the polyline decimate and subdivide block, with bind
module pds_checker import pds_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [POINT_W-1:0] out_x_i,
  input logic [POINT_W-1:0] out_y_i,
  input logic               out_vertex_i,
  input logic               out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("point dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i) &&
      $stable(out_vertex_i) && $stable(out_last_i))
    else $error("point changed while stalled");

  a_vertex_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_vertex_i == out_last_i)
    else $error("vertex and end of run disagree");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) || $past(in_valid_i && in_ready_i && !rst_ni) |-> !out_valid_i)
    else $error("point right after reset");

endmodule

bind polyline_decimate_subdivide_top pds_checker u_pds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_vtx.valid),
  .in_ready_i   (in_vtx.ready),
  .out_valid_i  (out_pt.valid),
  .out_ready_i  (out_pt.ready),
  .out_x_i      (out_pt.point_x),
  .out_y_i      (out_pt.point_y),
  .out_vertex_i (out_pt.is_vertex),
  .out_last_i   (out_pt.last_of_run)
);
